// ----- design/cbf_pkg.sv -----
// Package: sizes, hash constants and codes shared by the counting Bloom filter.
package cbf_pkg;

    localparam int NUM_COUNTERS = 4096;
    localparam int COUNTER_BITS = 4;
    localparam int MAX_HASHES   = 16;

    localparam int ADDR_W = $clog2(NUM_COUNTERS);
    localparam int MOD_W  = $clog2(NUM_COUNTERS + 1);
    localparam int HC_W   = $clog2(MAX_HASHES + 1);

    localparam logic [63:0] MIX_MUL   = 64'hc6a4a7935bd1e995;
    localparam logic [31:0] MUL_LO    = 32'h5bd1e995;
    localparam logic [31:0] MUL_HI    = 32'hc6a4a793;
    localparam int          MIX_SHIFT = 47;

    typedef enum logic [1:0] {
        ACT_FIND   = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_ERASE  = 2'd2,
        ACT_SPARE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_PRESENT   = 2'd0,
        ST_ABSENT    = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_UNDERFLOW = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        REG_SEED_A  = 2'd0,
        REG_SEED_B  = 2'd1,
        REG_HASH_CT = 2'd2,
        REG_CIU     = 2'd3
    } reg_index_t;

endpackage

// ----- design/cbf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module cbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/counting_bloom_filter.sv -----
// Counting Bloom filter: two MurmurHash64A hashes, 4096 x 4-bit counters in RAM.
// Steps per item, with one shared 32x32 multiplier: an accept step, a length-seed product
// on a key's first word, then folding of an empty, tail or full word; a last word adds
// finalizing, bit-serial remainders (a, b, 2^64 mod m), a read and a check per probed
// counter and the load of the output register.
// One item at a time, plus output stalls; reset clears all counters in one pass.
module counting_bloom_filter
    import cbf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [63:0] key_word,
    input  logic [3:0]  valid_bytes,
    input  logic [15:0] key_length,
    input  logic        last_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status
);

    typedef enum logic [17:0] {
        S_CLEAR = 18'h00001,
        S_IDLE  = 18'h00002,
        S_MUL   = 18'h00004,
        S_DIV   = 18'h00008,
        S_FOLD  = 18'h00010,
        S_K1    = 18'h00020,
        S_K2    = 18'h00040,
        S_HB    = 18'h00080,
        S_HBD   = 18'h00100,
        S_WCHK  = 18'h00200,
        S_FA    = 18'h00400,
        S_FB    = 18'h00800,
        S_RA    = 18'h01000,
        S_RB    = 18'h02000,
        S_RR    = 18'h04000,
        S_PRD   = 18'h08000,
        S_PCHK  = 18'h10000,
        S_OUT   = 18'h20000
    } state_t;

    localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;

    state_t state_reg, state_next, ret_reg, ret_next;

    logic [63:0] seed_a_reg, seed_a_next, seed_b_reg, seed_b_next;
    logic [4:0]  hc_reg, hc_next;
    logic [12:0] ciu_reg, ciu_next;

    logic [1:0]  mcnt_reg, mcnt_next;
    logic [63:0] mx_reg, mx_next, prod_reg, prod_next, acc_reg, acc_next;
    logic [63:0] mres_reg, mres_next;
    logic [5:0]  rcnt_reg, rcnt_next;
    logic [63:0] rsh_reg, rsh_next;
    logic [MOD_W-1:0] rrem_reg, rrem_next;

    logic [63:0] ha_reg, ha_next, hb_reg, hb_next, s_reg, s_next;
    logic [63:0] word_reg, word_next;
    logic [3:0]  nb_reg, nb_next;
    logic        last_reg, last_next;
    action_t     act_reg, act_next;
    logic        seed_pend_reg, seed_pend_next;
    logic        in_key_reg, in_key_next;

    logic [MOD_W-1:0] pos_reg, pos_next, bm_reg, bm_next, wr_reg, wr_next;
    logic [HC_W-1:0]  i_reg, i_next, cnt_reg, cnt_next;
    status_t          res_reg, res_next;
    logic             ov_reg, ov_next;
    logic [1:0]       st_reg, st_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;

    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_waddr, ram_raddr;
    logic [COUNTER_BITS-1:0] ram_wdata, ram_rdata;

    logic [MOD_W-1:0] mod_w;
    logic [HC_W-1:0]  hc_clamp;
    logic [31:0]      mul_a, mul_b;
    logic [MOD_W:0]   div_t, p1;
    logic [64:0]      s_sum;
    logic [63:0]      base_a, base_b, tmask;

    function automatic logic [63:0] xs(input logic [63:0] v);
        xs = v ^ (v >> MIX_SHIFT);
    endfunction

    cbf_ram #(
        .WIDTH (COUNTER_BITS),
        .DEPTH (NUM_COUNTERS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = ov_reg;
    assign status    = st_reg;

    always_comb
    begin
        if (ciu_reg == '0)
            mod_w = MOD_W'(1);
        else if (32'(ciu_reg) > 32'(NUM_COUNTERS))
            mod_w = MOD_W'(NUM_COUNTERS);
        else
            mod_w = MOD_W'(ciu_reg);
        if (32'(hc_reg) > 32'(MAX_HASHES))
            hc_clamp = HC_W'(MAX_HASHES);
        else
            hc_clamp = HC_W'(hc_reg);
    end

    // one 32x32 product per cycle; low 64 bits of x*MIX_MUL in four steps
    assign mul_a     = (mcnt_reg == 2'd2) ? mx_reg[63:32] : mx_reg[31:0];
    assign mul_b     = (mcnt_reg == 2'd1) ? MUL_HI : MUL_LO;
    assign div_t     = {rrem_reg, rsh_reg[63]};

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        seed_a_next    = seed_a_reg;
        seed_b_next    = seed_b_reg;
        hc_next        = hc_reg;
        ciu_next       = ciu_reg;
        mcnt_next      = mcnt_reg;
        mx_next        = mx_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        mres_next      = mres_reg;
        rcnt_next      = rcnt_reg;
        rsh_next       = rsh_reg;
        rrem_next      = rrem_reg;
        ha_next        = ha_reg;
        hb_next        = hb_reg;
        s_next         = s_reg;
        word_next      = word_reg;
        nb_next        = nb_reg;
        last_next      = last_reg;
        act_next       = act_reg;
        seed_pend_next = seed_pend_reg;
        in_key_next    = in_key_reg;
        pos_next       = pos_reg;
        bm_next        = bm_reg;
        wr_next        = wr_reg;
        i_next         = i_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        ov_next        = ov_reg;
        st_next        = st_reg;
        clr_next       = clr_reg;
        ram_we         = 1'b0;
        ram_waddr      = pos_reg[ADDR_W-1:0];
        ram_wdata      = '0;
        ram_raddr      = pos_reg[ADDR_W-1:0];
        base_a         = ha_reg;
        base_b         = hb_reg;
        tmask          = '0;
        p1             = '0;
        s_sum          = '0;

        if (cfg_write)
        begin
            case (cfg_index)
                REG_SEED_A:  seed_a_next = cfg_data;
                REG_SEED_B:  seed_b_next = cfg_data;
                REG_HASH_CT: hc_next     = cfg_data[4:0];
                REG_CIU:     ciu_next    = cfg_data[12:0];
                default:     ;
            endcase
        end

        if (ov_reg && !out_stall)
            ov_next = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(NUM_COUNTERS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    word_next      = key_word;
                    nb_next        = valid_bytes;
                    last_next      = last_word;
                    act_next       = action_t'(action);
                    seed_pend_next = !in_key_reg;
                    mx_next        = {48'b0, key_length};
                    mcnt_next      = '0;
                    ret_next       = S_FOLD;
                    state_next     = in_key_reg ? S_FOLD : S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next = mul_a * mul_b;
                mcnt_next = mcnt_reg + 1'b1;
                case (mcnt_reg)
                    2'd1:    acc_next = prod_reg;
                    2'd2:    acc_next = acc_reg + {prod_reg[31:0], 32'b0};
                    2'd3:
                    begin
                        mres_next  = acc_reg + {prod_reg[31:0], 32'b0};
                        state_next = ret_reg;
                    end
                    default: ;
                endcase
            end
            S_DIV:
            begin
                if (div_t >= {1'b0, mod_w})
                    rrem_next = MOD_W'(div_t - {1'b0, mod_w});
                else
                    rrem_next = div_t[MOD_W-1:0];
                rsh_next  = {rsh_reg[62:0], 1'b0};
                rcnt_next = rcnt_reg + 1'b1;
                if (rcnt_reg == 6'd63)
                    state_next = ret_reg;
            end
            S_FOLD:
            begin
                if (seed_pend_reg)
                begin
                    base_a = seed_a_reg ^ mres_reg;
                    base_b = seed_b_reg ^ mres_reg;
                end
                seed_pend_next = 1'b0;
                mcnt_next      = '0;
                ha_next        = base_a;
                hb_next        = base_b;
                if (nb_reg >= 4'd8)
                begin
                    mx_next    = word_reg;
                    ret_next   = S_K1;
                    state_next = S_MUL;
                end
                else if (nb_reg != 4'd0)
                begin
                    tmask      = (64'h1 << {nb_reg[2:0], 3'b000}) - 64'h1;
                    ha_next    = base_a ^ (word_reg & tmask);
                    hb_next    = base_b ^ (word_reg & tmask);
                    mx_next    = base_a ^ (word_reg & tmask);
                    ret_next   = S_HB;
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = S_WCHK;
                end
            end
            S_K1:
            begin
                mx_next    = xs(mres_reg);
                mcnt_next  = '0;
                ret_next   = S_K2;
                state_next = S_MUL;
            end
            S_K2:
            begin
                hb_next    = hb_reg ^ mres_reg;
                mx_next    = ha_reg ^ mres_reg;
                mcnt_next  = '0;
                ret_next   = S_HB;
                state_next = S_MUL;
            end
            S_HB:
            begin
                ha_next    = mres_reg;
                mx_next    = hb_reg;
                mcnt_next  = '0;
                ret_next   = S_HBD;
                state_next = S_MUL;
            end
            S_HBD:
            begin
                hb_next    = mres_reg;
                state_next = S_WCHK;
            end
            S_WCHK:
            begin
                if (!last_reg)
                begin
                    in_key_next = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    in_key_next = 1'b0;
                    mx_next     = xs(ha_reg);
                    mcnt_next   = '0;
                    ret_next    = S_FA;
                    state_next  = S_MUL;
                end
            end
            S_FA:
            begin
                ha_next    = xs(mres_reg);
                mx_next    = xs(hb_reg);
                mcnt_next  = '0;
                ret_next   = S_FB;
                state_next = S_MUL;
            end
            S_FB:
            begin
                hb_next    = xs(mres_reg);
                rsh_next   = ha_reg;
                rrem_next  = '0;
                rcnt_next  = '0;
                ret_next   = S_RA;
                state_next = S_DIV;
            end
            S_RA:
            begin
                pos_next   = rrem_reg;
                s_next     = ha_reg;
                rsh_next   = hb_reg;
                rrem_next  = '0;
                rcnt_next  = '0;
                ret_next   = S_RB;
                state_next = S_DIV;
            end
            S_RB:
            begin
                bm_next    = rrem_reg;
                rsh_next   = '1;
                rrem_next  = '0;
                rcnt_next  = '0;
                ret_next   = S_RR;
                state_next = S_DIV;
            end
            S_RR:
            begin
                // 2^64 mod m from (2^64 - 1) mod m
                if (rrem_reg + 1'b1 == mod_w)
                    wr_next = '0;
                else
                    wr_next = rrem_reg + 1'b1;
                i_next     = '0;
                cnt_next   = hc_clamp;
                res_next   = ST_PRESENT;
                state_next = (hc_clamp == '0) ? S_OUT : S_PRD;
            end
            S_PRD:
            begin
                state_next = S_PCHK;
            end
            S_PCHK:
            begin
                i_next = i_reg + 1'b1;
                case (act_reg)
                    ACT_INSERT:
                    begin
                        if (ram_rdata == CNT_MAX)
                            res_next = ST_OVERFLOW;
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = ram_rdata + 1'b1;
                        end
                    end
                    ACT_ERASE:
                    begin
                        if (ram_rdata == '0)
                            res_next = ST_UNDERFLOW;
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = ram_rdata - 1'b1;
                        end
                    end
                    default:
                    begin
                        if (ram_rdata == '0)
                            res_next = ST_ABSENT;
                    end
                endcase
                // advance a + b*i, folding back the 2^64 wrap of the sum
                s_sum  = {1'b0, s_reg} + {1'b0, hb_reg};
                s_next = s_sum[63:0];
                p1     = {1'b0, pos_reg} + {1'b0, bm_reg};
                if (p1 >= {1'b0, mod_w})
                    p1 = p1 - {1'b0, mod_w};
                if (s_sum[64])
                begin
                    if (p1 >= {1'b0, wr_reg})
                        p1 = p1 - {1'b0, wr_reg};
                    else
                        p1 = p1 + {1'b0, mod_w} - {1'b0, wr_reg};
                end
                pos_next = p1[MOD_W-1:0];
                if (res_next != ST_PRESENT || i_reg + 1'b1 == cnt_reg)
                    state_next = S_OUT;
                else
                    state_next = S_PRD;
            end
            S_OUT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next    = 1'b1;
                    st_next    = res_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            ret_reg       <= S_IDLE;
            seed_a_reg    <= '0;
            seed_b_reg    <= '0;
            hc_reg        <= 5'd3;
            ciu_reg       <= 13'd4096;
            mcnt_reg      <= '0;
            rcnt_reg      <= '0;
            seed_pend_reg <= 1'b0;
            in_key_reg    <= 1'b0;
            i_reg         <= '0;
            ov_reg        <= 1'b0;
            clr_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            seed_a_reg    <= seed_a_next;
            seed_b_reg    <= seed_b_next;
            hc_reg        <= hc_next;
            ciu_reg       <= ciu_next;
            mcnt_reg      <= mcnt_next;
            rcnt_reg      <= rcnt_next;
            seed_pend_reg <= seed_pend_next;
            in_key_reg    <= in_key_next;
            i_reg         <= i_next;
            ov_reg        <= ov_next;
            clr_reg       <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mx_reg   <= mx_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        mres_reg <= mres_next;
        rsh_reg  <= rsh_next;
        rrem_reg <= rrem_next;
        ha_reg   <= ha_next;
        hb_reg   <= hb_next;
        s_reg    <= s_next;
        word_reg <= word_next;
        nb_reg   <= nb_next;
        last_reg <= last_next;
        act_reg  <= act_next;
        pos_reg  <= pos_next;
        bm_reg   <= bm_next;
        wr_reg   <= wr_next;
        cnt_reg  <= cnt_next;
        res_reg  <= res_next;
        st_reg   <= st_next;
    end

`ifndef NO_ASSERTIONS
    a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> in_stall)
        else $error("input taken during counter clear");

    a_find_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PCHK && ram_we) |-> (act_reg == ACT_INSERT || act_reg == ACT_ERASE))
        else $error("counter written on a find");

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PRD) |-> (pos_reg < mod_w && i_reg < cnt_reg))
        else $error("probe position or index out of range");
`endif

endmodule
